[rtl/sti_pkg.sv]
// Shared widths for the symmetric tensor invariants unit.
// Holds the fixed field widths of the input components and result invariants.
// Has no dependencies.
package sti_pkg;

  localparam int unsigned CompW    = 16;  // Q8.8 input component
  localparam int unsigned DevW     = 18;  // scaled deviatoric entries and trace
  localparam int unsigned Prod2W   = 2 * CompW;
  localparam int unsigned DevProdW = 2 * DevW;
  localparam int unsigned Prod3W   = Prod2W + CompW;
  localparam int unsigned DevTriW  = DevProdW + DevW;

  localparam int unsigned FirstW   = 18;
  localparam int unsigned SecondW  = 33;
  localparam int unsigned ThirdW   = 49;
  localparam int unsigned DevSecW  = 35;
  localparam int unsigned DevThrW  = 57;

  // Accumulator widths with headroom above each result.
  localparam int unsigned SecondAccW = SecondW + 2;
  localparam int unsigned DevSecAccW = DevSecW + 2;
  localparam int unsigned ThirdAccW  = ThirdW + 1;
  localparam int unsigned DevThrAccW = DevThrW + 1;

endpackage

[rtl/symmetric_tensor_invariants_unit.sv]
// Symmetric 3x3 tensor invariants in a four-stage multiplier pipeline.
// Depends on sti_pkg for field and intermediate widths.
//
// Usage: one tensor (six signed Q8.8 values xx,yy,zz,xy,xz,yz) is moved per
// input transaction on in_valid_i/in_ready_o. Each tensor yields exactly one
// result transaction on out_valid_o/out_ready_i carrying I1, I2, I3, 3*J2
// and 27*J3, all exact integers.
// A tensor accepted into stage 1 moves on through stages 2 and 3 to stage 4,
// whose valid bit drives out_valid_o. Throughput is one tensor per cycle
// while the receiver keeps up; the depth is set by two rows of multipliers
// (pairwise products, then triple products) plus the linear stage in front
// and the summing stage behind.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles are squeezed out. When the receiver stalls,
// the last stage holds its result and the stages in front keep filling;
// in_ready_o drops only once all four stages are occupied.
// Reset clears only the valid bits; the data registers have no reset.
module symmetric_tensor_invariants_unit
  import sti_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [CompW-1:0]    comp_xx_i,
  input  logic signed [CompW-1:0]    comp_yy_i,
  input  logic signed [CompW-1:0]    comp_zz_i,
  input  logic signed [CompW-1:0]    comp_xy_i,
  input  logic signed [CompW-1:0]    comp_xz_i,
  input  logic signed [CompW-1:0]    comp_yz_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [FirstW-1:0]   first_inv_o,
  output logic signed [SecondW-1:0]  second_inv_o,
  output logic signed [ThirdW-1:0]   third_inv_o,
  output logic        [DevSecW-1:0]  dev_second_x3_o,
  output logic signed [DevThrW-1:0]  dev_third_x27_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Stage 1: register components, trace and scaled deviatoric entries.
  logic signed [CompW-1:0] xx1_q, yy1_q, zz1_q, xy1_q, xz1_q, yz1_q;
  logic signed [DevW-1:0]  i1_1_d, i1_1_q;
  logic signed [DevW-1:0]  da1_d, db1_d, dc1_d, dd1_d, de1_d, df1_d;
  logic signed [DevW-1:0]  da1_q, db1_q, dc1_q, dd1_q, de1_q, df1_q;

  always_comb begin
    i1_1_d = DevW'(comp_xx_i) + DevW'(comp_yy_i) + DevW'(comp_zz_i);
    // 3*d - I1 reduces to twice d minus the other two diagonals.
    da1_d  = (DevW'(comp_xx_i) <<< 1) - DevW'(comp_yy_i) - DevW'(comp_zz_i);
    db1_d  = (DevW'(comp_yy_i) <<< 1) - DevW'(comp_xx_i) - DevW'(comp_zz_i);
    dc1_d  = (DevW'(comp_zz_i) <<< 1) - DevW'(comp_xx_i) - DevW'(comp_yy_i);
    dd1_d  = (DevW'(comp_xy_i) <<< 1) + DevW'(comp_xy_i);
    de1_d  = (DevW'(comp_xz_i) <<< 1) + DevW'(comp_xz_i);
    df1_d  = (DevW'(comp_yz_i) <<< 1) + DevW'(comp_yz_i);
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      xx1_q  <= comp_xx_i;
      yy1_q  <= comp_yy_i;
      zz1_q  <= comp_zz_i;
      xy1_q  <= comp_xy_i;
      xz1_q  <= comp_xz_i;
      yz1_q  <= comp_yz_i;
      i1_1_q <= i1_1_d;
      da1_q  <= da1_d;
      db1_q  <= db1_d;
      dc1_q  <= dc1_d;
      dd1_q  <= dd1_d;
      de1_q  <= de1_d;
      df1_q  <= df1_d;
    end
  end

  // Stage 2: pairwise products.
  logic signed [CompW-1:0]    xx2_q, yy2_q, zz2_q, yz2_q;
  logic signed [DevW-1:0]     i1_2_q, da2_q, db2_q, dc2_q, df2_q;
  logic signed [Prod2W-1:0]   pxy2_q, pyz2_q, pxz2_q, sxy2_q, sxz2_q, syz2_q, pde2_q;
  logic signed [DevProdW-1:0] i1sq2_q, qab2_q, qde2_q, sqd2_q, sqe2_q, sqf2_q;

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      xx2_q   <= xx1_q;
      yy2_q   <= yy1_q;
      zz2_q   <= zz1_q;
      yz2_q   <= yz1_q;
      i1_2_q  <= i1_1_q;
      da2_q   <= da1_q;
      db2_q   <= db1_q;
      dc2_q   <= dc1_q;
      df2_q   <= df1_q;
      pxy2_q  <= Prod2W'(xx1_q) * Prod2W'(yy1_q);
      pyz2_q  <= Prod2W'(yy1_q) * Prod2W'(zz1_q);
      pxz2_q  <= Prod2W'(xx1_q) * Prod2W'(zz1_q);
      sxy2_q  <= Prod2W'(xy1_q) * Prod2W'(xy1_q);
      sxz2_q  <= Prod2W'(xz1_q) * Prod2W'(xz1_q);
      syz2_q  <= Prod2W'(yz1_q) * Prod2W'(yz1_q);
      pde2_q  <= Prod2W'(xy1_q) * Prod2W'(xz1_q);
      i1sq2_q <= DevProdW'(i1_1_q) * DevProdW'(i1_1_q);
      qab2_q  <= DevProdW'(da1_q) * DevProdW'(db1_q);
      qde2_q  <= DevProdW'(dd1_q) * DevProdW'(de1_q);
      sqd2_q  <= DevProdW'(dd1_q) * DevProdW'(dd1_q);
      sqe2_q  <= DevProdW'(de1_q) * DevProdW'(de1_q);
      sqf2_q  <= DevProdW'(df1_q) * DevProdW'(df1_q);
    end
  end

  // Stage 3: triple products and the second invariant.
  logic signed [DevW-1:0]       i1_3_q;
  logic signed [DevProdW-1:0]   i1sq3_q;
  logic signed [SecondAccW-1:0] i2_3_d;
  logic signed [SecondW-1:0]    i2_3_q;
  logic signed [Prod3W-1:0]     t_abc3_q, t_def3_q, t_aff3_q, t_bee3_q, t_cdd3_q;
  logic signed [DevTriW-1:0]    u_abc3_q, u_def3_q, u_aff3_q, u_bee3_q, u_cdd3_q;

  assign i2_3_d = SecondAccW'(pxy2_q) + SecondAccW'(pyz2_q) + SecondAccW'(pxz2_q)
                - SecondAccW'(sxy2_q) - SecondAccW'(sxz2_q) - SecondAccW'(syz2_q);

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      i1_3_q   <= i1_2_q;
      i1sq3_q  <= i1sq2_q;
      i2_3_q   <= i2_3_d[SecondW-1:0];
      t_abc3_q <= Prod3W'(pxy2_q) * Prod3W'(zz2_q);
      t_def3_q <= Prod3W'(pde2_q) * Prod3W'(yz2_q);
      t_aff3_q <= Prod3W'(syz2_q) * Prod3W'(xx2_q);
      t_bee3_q <= Prod3W'(sxz2_q) * Prod3W'(yy2_q);
      t_cdd3_q <= Prod3W'(sxy2_q) * Prod3W'(zz2_q);
      u_abc3_q <= DevTriW'(qab2_q) * DevTriW'(dc2_q);
      u_def3_q <= DevTriW'(qde2_q) * DevTriW'(df2_q);
      u_aff3_q <= DevTriW'(sqf2_q) * DevTriW'(da2_q);
      u_bee3_q <= DevTriW'(sqe2_q) * DevTriW'(db2_q);
      u_cdd3_q <= DevTriW'(sqd2_q) * DevTriW'(dc2_q);
    end
  end

  // Stage 4: final sums into the output register.
  logic signed [DevSecAccW-1:0] j2_4_d;
  logic signed [ThirdAccW-1:0]  i3_4_d;
  logic signed [DevThrAccW-1:0] j3_4_d;
  logic signed [FirstW-1:0]     i1_4_q;
  logic signed [SecondW-1:0]    i2_4_q;
  logic signed [ThirdW-1:0]     i3_4_q;
  logic        [DevSecW-1:0]    j2_4_q;
  logic signed [DevThrW-1:0]    j3_4_q;

  always_comb begin
    j2_4_d = DevSecAccW'(i1sq3_q) - (DevSecAccW'(i2_3_q) <<< 1) - DevSecAccW'(i2_3_q);
    i3_4_d = ThirdAccW'(t_abc3_q) + (ThirdAccW'(t_def3_q) <<< 1)
           - ThirdAccW'(t_aff3_q) - ThirdAccW'(t_bee3_q) - ThirdAccW'(t_cdd3_q);
    j3_4_d = DevThrAccW'(u_abc3_q) + (DevThrAccW'(u_def3_q) <<< 1)
           - DevThrAccW'(u_aff3_q) - DevThrAccW'(u_bee3_q) - DevThrAccW'(u_cdd3_q);
  end

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      i1_4_q <= FirstW'(i1_3_q);
      i2_4_q <= i2_3_q;
      i3_4_q <= i3_4_d[ThirdW-1:0];
      j2_4_q <= j2_4_d[DevSecW-1:0];
      j3_4_q <= j3_4_d[DevThrW-1:0];
    end
  end

  assign out_valid_o     = v4_q;
  assign first_inv_o     = i1_4_q;
  assign second_inv_o    = i2_4_q;
  assign third_inv_o     = i3_4_q;
  assign dev_second_x3_o = j2_4_q;
  assign dev_third_x27_o = j3_4_q;

  // 3*J2 is a sum of squares, so a negative value means a broken datapath.
  a_j2_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> !j2_4_d[DevSecAccW-1])
    else $error("3*J2 came out negative");

  // A full pipeline facing a stalled receiver must refuse new input.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted into a full, stalled pipeline");

  // A result that was not taken must still be there in the next cycle.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(j3_4_q) && $stable(i3_4_q)))
    else $error("stalled result was lost or changed");

endmodule

[test/tb.sv]
// Self-checking testbench for symmetric_tensor_invariants_unit.
// Drives tensors through the valid/ready input, predicts all five invariants
// in 64-bit integer arithmetic and compares every result transaction in order.
// Depends on sti_pkg and the RTL of the unit; needs nothing else.
module tb;
  import sti_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic signed [CompW-1:0] xx;
    logic signed [CompW-1:0] yy;
    logic signed [CompW-1:0] zz;
    logic signed [CompW-1:0] xy;
    logic signed [CompW-1:0] xz;
    logic signed [CompW-1:0] yz;
  } tensor_t;

  typedef struct packed {
    logic signed [FirstW-1:0]  first_inv;
    logic signed [SecondW-1:0] second_inv;
    logic signed [ThirdW-1:0]  third_inv;
    logic        [DevSecW-1:0] dev_second_x3;
    logic signed [DevThrW-1:0] dev_third_x27;
  } invariants_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [CompW-1:0]   comp_xx_i = '0;
  logic signed [CompW-1:0]   comp_yy_i = '0;
  logic signed [CompW-1:0]   comp_zz_i = '0;
  logic signed [CompW-1:0]   comp_xy_i = '0;
  logic signed [CompW-1:0]   comp_xz_i = '0;
  logic signed [CompW-1:0]   comp_yz_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [FirstW-1:0]  first_inv_o;
  logic signed [SecondW-1:0] second_inv_o;
  logic signed [ThirdW-1:0]  third_inv_o;
  logic        [DevSecW-1:0] dev_second_x3_o;
  logic signed [DevThrW-1:0] dev_third_x27_o;

  invariants_t expected_invariants[$];
  invariants_t want;
  invariants_t got;
  tensor_t     accepted_tensor;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          error_count = 0;
  int          checked_count = 0;
  int          sent_count = 0;
  int unsigned cycle_count = 0;

  symmetric_tensor_invariants_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .comp_xx_i,
    .comp_yy_i,
    .comp_zz_i,
    .comp_xy_i,
    .comp_xz_i,
    .comp_yz_i,
    .out_valid_o,
    .out_ready_i,
    .first_inv_o,
    .second_inv_o,
    .third_inv_o,
    .dev_second_x3_o,
    .dev_third_x27_o
  );

  always #10 clk_i = ~clk_i;

  // Determinant of a symmetric matrix given by its diagonal and off-diagonals.
  function automatic longint sym_determinant(longint a, longint b, longint c,
                                             longint d, longint e, longint f);
    return a * b * c + 2 * d * e * f - a * f * f - b * e * e - c * d * d;
  endfunction

  function automatic invariants_t invariants_of(tensor_t t);
    longint xx, yy, zz, xy, xz, yz;
    longint trace, second, third, dev_sec, dev_thr;
    invariants_t r;
    xx = longint'(t.xx);
    yy = longint'(t.yy);
    zz = longint'(t.zz);
    xy = longint'(t.xy);
    xz = longint'(t.xz);
    yz = longint'(t.yz);
    trace   = xx + yy + zz;
    second  = xx * yy + yy * zz + xx * zz - xy * xy - xz * xz - yz * yz;
    third   = sym_determinant(xx, yy, zz, xy, xz, yz);
    dev_sec = trace * trace - 3 * second;
    // Deviator scaled by three keeps every entry an integer.
    dev_thr = sym_determinant(3 * xx - trace, 3 * yy - trace, 3 * zz - trace,
                              3 * xy, 3 * xz, 3 * yz);
    r.first_inv     = trace[FirstW-1:0];
    r.second_inv    = second[SecondW-1:0];
    r.third_inv     = third[ThirdW-1:0];
    r.dev_second_x3 = dev_sec[DevSecW-1:0];
    r.dev_third_x27 = dev_thr[DevThrW-1:0];
    return r;
  endfunction

  function automatic tensor_t make_tensor(int xx, int yy, int zz, int xy, int xz, int yz);
    tensor_t t;
    t.xx = xx[CompW-1:0];
    t.yy = yy[CompW-1:0];
    t.zz = zz[CompW-1:0];
    t.xy = xy[CompW-1:0];
    t.xz = xz[CompW-1:0];
    t.yz = yz[CompW-1:0];
    return t;
  endfunction

  function automatic logic [CompW-1:0] extreme_component();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  // Full-range tensors half the time, with extremes, small values, tensors with
  // nearly equal diagonals and diagonal-only tensors mixed in to reach the corners of the arithmetic.
  function automatic tensor_t random_tensor();
    tensor_t t;
    logic [CompW-1:0] base;
    int kind;
    t = {$urandom, $urandom, $urandom};
    kind = $urandom_range(9);
    if (kind == 5 || kind == 6) begin
      t = {extreme_component(), extreme_component(), extreme_component(),
           extreme_component(), extreme_component(), extreme_component()};
    end else if (kind == 7) begin
      t = make_tensor($urandom_range(64) - 32, $urandom_range(64) - 32,
                      $urandom_range(64) - 32, $urandom_range(64) - 32,
                      $urandom_range(64) - 32, $urandom_range(64) - 32);
    end else if (kind == 8) begin
      base = CompW'($urandom);
      t.xx = base;
      t.yy = base + CompW'($urandom_range(2));
      t.zz = base - CompW'($urandom_range(2));
    end else if (kind == 9) begin
      t.xy = '0;
      t.xz = '0;
      t.yz = '0;
    end
    return t;
  endfunction

  // Sends one tensor; returns on the falling edge after its transaction.
  task automatic send_tensor(tensor_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    {comp_xx_i, comp_yy_i, comp_zz_i, comp_xy_i, comp_xz_i, comp_yz_i} = t;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_invariants.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic run_random_phase(int count, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_tensor(random_tensor());
    drain_results();
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_tensor(make_tensor(0, 0, 0, 0, 0, 0));
    send_tensor(make_tensor(256, 256, 256, 0, 0, 0));
    send_tensor(make_tensor(32767, 32767, 32767, 32767, 32767, 32767));
    send_tensor(make_tensor(-32768, -32768, -32768, -32768, -32768, -32768));
    send_tensor(make_tensor(32767, 32767, 32767, 0, 0, 0));
    send_tensor(make_tensor(-32768, -32768, -32768, 0, 0, 0));
    send_tensor(make_tensor(0, 0, 0, -32768, -32768, -32768));
    send_tensor(make_tensor(0, 0, 0, 32767, 32767, 32767));
    send_tensor(make_tensor(32767, -32768, -32768, 0, 0, 0));
    send_tensor(make_tensor(-32768, 32767, 32767, 0, 0, 0));
    send_tensor(make_tensor(32767, 32767, 32767, -32768, -32768, -32768));
    send_tensor(make_tensor(-32768, -32768, -32768, 32767, 32767, 32767));
    send_tensor(make_tensor(32767, -32768, 0, -32768, 32767, -32768));
    send_tensor(make_tensor(-32768, 32767, -32768, 32767, -32768, 32767));
    // Hydrostatic tensors have a zero deviator.
    send_tensor(make_tensor(-1234, -1234, -1234, 0, 0, 0));
    send_tensor(make_tensor(0, 0, 0, 512, 0, 0));
    send_tensor(make_tensor(-1, -1, -1, -1, -1, -1));
    send_tensor(make_tensor(1, 1, 1, 1, 1, 1));
    send_tensor(make_tensor(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555));
    send_tensor(make_tensor(16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa));
    drain_results();
  endtask

  task automatic test_back_to_back();
    run_random_phase(480, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(470, 59, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_phase(470, 0, 59);
  endtask

  task automatic test_mixed_flow();
    run_random_phase(480, 16, 16);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
  end

  // Records each accepted tensor and checks each result transaction in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accepted_tensor = {comp_xx_i, comp_yy_i, comp_zz_i, comp_xy_i, comp_xz_i, comp_yz_i};
        expected_invariants.push_back(invariants_of(accepted_tensor));
      end
      if (out_valid_o && out_ready_i) begin
        got = {first_inv_o, second_inv_o, third_inv_o, dev_second_x3_o, dev_third_x27_o};
        if (expected_invariants.size() == 0) begin
          $error("result transaction with no tensor outstanding");
          error_count++;
        end else begin
          want = expected_invariants.pop_front();
          checked_count++;
          if (got.first_inv !== want.first_inv) begin
            $error("first_inv: expected %0d, got %0d", want.first_inv, got.first_inv);
            error_count++;
          end
          if (got.second_inv !== want.second_inv) begin
            $error("second_inv: expected %0d, got %0d", want.second_inv, got.second_inv);
            error_count++;
          end
          if (got.third_inv !== want.third_inv) begin
            $error("third_inv: expected %0d, got %0d", want.third_inv, got.third_inv);
            error_count++;
          end
          if (got.dev_second_x3 !== want.dev_second_x3) begin
            $error("dev_second_x3: expected %0d, got %0d",
                   want.dev_second_x3, got.dev_second_x3);
            error_count++;
          end
          if (got.dev_third_x27 !== want.dev_third_x27) begin
            $error("dev_third_x27: expected %0d, got %0d",
                   want.dev_third_x27, got.dev_third_x27);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_invariants.size());
      $display("** symmetric_tensor_invariants_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_flow();
    $display("Sent %0d tensors and checked %0d results: directed corners, then random",
             sent_count, checked_count);
    $display("tensors back to back, with sender gaps, receiver stalls and both.");
    if (error_count == 0 && expected_invariants.size() == 0) begin
      $display("** symmetric_tensor_invariants_unit: PASSED **");
    end else begin
      $display("** symmetric_tensor_invariants_unit: FAILED **");
    end
    $finish;
  end

endmodule
